FILE: sv/drac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the damage rectangle accumulator.
// No dependencies; used by drac_ctrl and damage_rect_accumulator.
package drac_pkg;

	localparam int MAX_RECTS = 8;
	localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNT_W     = $clog2(MAX_RECTS + 1);
	localparam int SLACK_W   = 16;
	localparam int AREA_W    = 32;

	localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd128;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// stored rectangle, x in the lowest bits
	typedef struct packed {
		logic [15:0] h;
		logic [15:0] w;
		logic [14:0] y;
		logic [14:0] x;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	typedef struct packed {
		logic        action;
		logic [14:0] x;
		logic [14:0] y;
		logic [14:0] w;
		logic [14:0] h;
	} item_t;

	// result request from the sequencer to the output register
	typedef struct packed {
		logic req;
		box_t rect;
		logic occupied;
		logic last;
	} res_t;

endpackage

FILE: sv/drac_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module drac_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 62,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/drac_ctrl.sv
`timescale 1ns / 1ps
// Sequencer and datapath: walks the rectangle RAM for merge, append, collapse
// and drain. Depends on drac_pkg and drac_ram.
module drac_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  drac_pkg::item_t               in_item,
	input  logic [drac_pkg::SLACK_W-1:0]  slack,
	output drac_pkg::res_t                res,
	input  logic                          res_ready
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_NAREA  = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_JOIN   = 4'd3;
	localparam logic [3:0] S_MENT   = 4'd4;
	localparam logic [3:0] S_MUNI   = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_APPEND = 4'd7;
	localparam logic [3:0] S_CRD    = 4'd8;
	localparam logic [3:0] S_CACC   = 4'd9;
	localparam logic [3:0] S_CWR    = 4'd10;
	localparam logic [3:0] S_DRD    = 4'd11;
	localparam logic [3:0] S_DOUT   = 4'd12;
	localparam logic [3:0] S_DEMPTY = 4'd13;

	localparam int CW = drac_pkg::CNT_W;
	localparam int IW = drac_pkg::IDX_W;
	localparam int AW = drac_pkg::AREA_W;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_inc;

	drac_pkg::box_t nb_q;
	drac_pkg::box_t ent_q;
	drac_pkg::box_t uni_q;
	drac_pkg::box_t acc_q;
	logic [AW-1:0]  area_new_q;
	logic [AW-1:0]  area_ent_q;
	logic [AW-1:0]  area_uni_q;

	drac_pkg::box_t rdata;
	logic [drac_pkg::BOX_W-1:0] rdata_raw;
	logic           we;
	logic [IW-1:0]  waddr;
	drac_pkg::box_t wdata;
	logic [IW-1:0]  raddr;

	drac_pkg::box_t join_a;
	drac_pkg::box_t join_r;
	logic [15:0]    mul_a;
	logic [15:0]    mul_b;
	logic [AW-1:0]  prod;
	logic [AW+1:0]  budget;
	logic           cheap;
	logic           is_last;
	logic           in_fire;
	logic           in_empty;

	function automatic drac_pkg::box_t box_join(drac_pkg::box_t a, drac_pkg::box_t b);
		logic signed [17:0] ax, bx, ay, by, ar, br, ab, bb, lx, ty, rx, bt, sw, sh;
		drac_pkg::box_t r;
		ax = {{3{a.x[14]}}, a.x};
		bx = {{3{b.x[14]}}, b.x};
		ay = {{3{a.y[14]}}, a.y};
		by = {{3{b.y[14]}}, b.y};
		ar = ax + {2'b00, a.w};
		br = bx + {2'b00, b.w};
		ab = ay + {2'b00, a.h};
		bb = by + {2'b00, b.h};
		lx = (ax < bx) ? ax : bx;
		ty = (ay < by) ? ay : by;
		rx = (ar > br) ? ar : br;
		bt = (ab > bb) ? ab : bb;
		sw = rx - lx;
		sh = bt - ty;
		r.x = lx[14:0];
		r.y = ty[14:0];
		r.w = sw[15:0];
		r.h = sh[15:0];
		return r;
	endfunction

	drac_ram #(
		.DEPTH(drac_pkg::MAX_RECTS),
		.WIDTH(drac_pkg::BOX_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rdata    = drac_pkg::box_t'(rdata_raw);
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign in_empty = (in_item.w == 15'd0) || (in_item.h == 15'd0);
	assign idx_inc  = idx_q + CW'(1);
	assign is_last  = (idx_inc == count_q);
	assign raddr    = idx_q[IW-1:0];

	assign join_a = (state_q == S_CACC) ? acc_q : nb_q;
	assign join_r = box_join(join_a, rdata);

	// one shared multiplier, operands picked by state
	always_comb begin
		case (state_q)
			S_MENT: begin
				mul_a = ent_q.w;
				mul_b = ent_q.h;
			end
			S_MUNI: begin
				mul_a = uni_q.w;
				mul_b = uni_q.h;
			end
			default: begin
				mul_a = nb_q.w;
				mul_b = nb_q.h;
			end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign budget = {2'b00, area_ent_q} + {2'b00, area_new_q} + {{(AW+2-drac_pkg::SLACK_W){1'b0}}, slack};
	assign cheap  = {2'b00, area_uni_q} <= budget;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = uni_q;
		case (state_q)
			S_CMP: begin
				we = cheap;
			end
			S_APPEND: begin
				we    = 1'b1;
				waddr = count_q[IW-1:0];
				wdata = nb_q;
			end
			S_CWR: begin
				we    = 1'b1;
				waddr = '0;
				wdata = acc_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.req      = 1'b0;
		res.rect     = rdata;
		res.occupied = 1'b1;
		res.last     = is_last;
		case (state_q)
			S_DOUT: begin
				res.req = 1'b1;
			end
			S_DEMPTY: begin
				res.req      = 1'b1;
				res.rect     = '0;
				res.occupied = 1'b0;
				res.last     = 1'b1;
			end
			default: begin
				res.req = 1'b0;
			end
		endcase
	end

	// every write lands before the sequencer returns to idle, so a read never
	// overlaps a pending write to the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_fire) begin
						if (in_item.action == drac_pkg::ACT_DRAIN) begin
							state_q <= (count_q == '0) ? S_DEMPTY : S_DRD;
						end else if (!in_empty) begin
							state_q <= S_NAREA;
						end
					end
				end
				S_NAREA: begin
					state_q <= (count_q == '0) ? S_APPEND : S_RD;
				end
				S_RD: begin
					state_q <= S_JOIN;
				end
				S_JOIN: begin
					state_q <= S_MENT;
				end
				S_MENT: begin
					state_q <= S_MUNI;
				end
				S_MUNI: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cheap) begin
						state_q <= S_IDLE;
					end else if (is_last) begin
						if (count_q < CW'(drac_pkg::MAX_RECTS)) begin
							state_q <= S_APPEND;
						end else begin
							idx_q   <= '0;
							state_q <= S_CRD;
						end
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_RD;
					end
				end
				S_APPEND: begin
					count_q <= count_q + CW'(1);
					state_q <= S_IDLE;
				end
				S_CRD: begin
					state_q <= S_CACC;
				end
				S_CACC: begin
					if (idx_q == CW'(drac_pkg::MAX_RECTS - 1)) begin
						state_q <= S_CWR;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_CRD;
					end
				end
				S_CWR: begin
					count_q <= CW'(1);
					state_q <= S_IDLE;
				end
				S_DRD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (res_ready) begin
						if (is_last) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= S_DRD;
						end
					end
				end
				S_DEMPTY: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			nb_q.x <= in_item.x;
			nb_q.y <= in_item.y;
			nb_q.w <= {1'b0, in_item.w};
			nb_q.h <= {1'b0, in_item.h};
		end
		case (state_q)
			S_NAREA: begin
				area_new_q <= prod;
			end
			S_JOIN: begin
				ent_q <= rdata;
				uni_q <= join_r;
			end
			S_MENT: begin
				area_ent_q <= prod;
			end
			S_MUNI: begin
				area_uni_q <= prod;
			end
			S_CMP: begin
				acc_q <= nb_q;
			end
			S_CACC: begin
				acc_q <= join_r;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/damage_rect_accumulator.sv
`timescale 1ns / 1ps
// Damage rectangle accumulator: top level with the stream ports, the slack
// register and the output register. Depends on drac_pkg and drac_ctrl.
//
// The block works on one request at a time; s_tready is high only while the
// sequencer is idle. An add computes the new area, then examines each stored
// entry in turn (RAM read, union, two passes through the shared 16x16
// multiplier, compare) and appends if none merges and the list has room;
// when the list is full and nothing merges, a collapse pass joins every
// entry into one bounding box. An empty rectangle is dropped in the cycle it
// is taken. A drain reads each stored rectangle, one step for the RAM read
// and one for the hand-off (a zero result when the list is empty), and
// stalls while the output register is full and m_tready is low. The output
// register lets a new request enter while the last result still waits.
module damage_rect_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // rect_x[14:0], rect_y[29:15], rect_w[44:30], rect_h[59:45]
	input  logic        s_tuser,   // action: 0 add, 1 drain
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_x[14:0], out_y[29:15], out_w[45:30], out_h[61:46]
	output logic        m_tuser,   // out_valid
	output logic        m_tlast,   // out_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // merge_slack
);

	logic [drac_pkg::SLACK_W-1:0] slack_q;
	drac_pkg::item_t item;
	drac_pkg::res_t  res;
	logic            res_ready;
	logic            ovalid_q;
	drac_pkg::box_t  orect_q;
	logic            oocc_q;
	logic            olast_q;

	assign item.action = s_tuser;
	assign item.x      = s_tdata[14:0];
	assign item.y      = s_tdata[29:15];
	assign item.w      = s_tdata[44:30];
	assign item.h      = s_tdata[59:45];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q <= drac_pkg::SLACK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slack_q <= cfg_data;
		end
	end

	drac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (item),
		.slack    (slack_q),
		.res      (res),
		.res_ready(res_ready)
	);

	// load when empty or being emptied this cycle
	assign res_ready = !ovalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_ready) begin
			ovalid_q <= res.req;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.req) begin
			orect_q <= res.rect;
			oocc_q  <= res.occupied;
			olast_q <= res.last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {{(64 - drac_pkg::BOX_W){1'b0}}, orect_q};
	assign m_tuser  = oocc_q;
	assign m_tlast  = olast_q;

endmodule

FILE: sv/drac_chk.sv
`timescale 1ns / 1ps
// Port-level checker for damage_rect_accumulator, attached with bind.
// Depends only on the top level's ports.
module drac_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 64'd0))
		else $error("empty-list result not a zero last result");

	a_nonzero_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[45:30] != 16'd0) && (m_tdata[61:46] != 16'd0))
		else $error("drained rectangle has zero size");

	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("drain request did not occupy the block");

endmodule

bind damage_rect_accumulator drac_chk u_drac_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

FILE: dv/damage_rect_accumulator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for damage_rect_accumulator: a stream driver and a
// monitor around a rectangle-list predictor. Depends on drac_pkg and the RTL.
module damage_rect_accumulator_test;

	localparam int CLK_HALF      = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} rect_t;

	typedef struct packed {
		logic [14:0] x;
		logic [14:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic        occupied;
		logic        last;
	} damage_out_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	drac_pkg::item_t request_q[$];
	damage_out_t     drained_rects_q[$];
	rect_t           rect_list[drac_pkg::MAX_RECTS];
	int          rect_count    = 0;
	int          merge_slack   = int'(drac_pkg::SLACK_RESET);
	logic        req_taken     = 1'b0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          cycle_count   = 0;
	int          error_count   = 0;
	int          n_adds        = 0;
	int          n_ignored     = 0;
	int          n_drains      = 0;
	int          n_results     = 0;

	damage_rect_accumulator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycle_count);
			$display("damage_rect_accumulator_test: errors");
			$finish;
		end
	end

	function automatic longint unsigned covered_area(rect_t r);
		if (r.w <= 0 || r.h <= 0)
			return 0;
		return longint'(r.w) * longint'(r.h);
	endfunction

	function automatic rect_t bounding_box(rect_t a, rect_t b);
		rect_t u;
		int right_a, right_b, bottom_a, bottom_b;
		right_a  = a.x + a.w;
		right_b  = b.x + b.w;
		bottom_a = a.y + a.h;
		bottom_b = b.y + b.h;
		u.x = (a.x < b.x) ? a.x : b.x;
		u.y = (a.y < b.y) ? a.y : b.y;
		u.w = ((right_a > right_b) ? right_a : right_b) - u.x;
		u.h = ((bottom_a > bottom_b) ? bottom_a : bottom_b) - u.y;
		return u;
	endfunction

	// Update the rectangle list for one accepted request; queue what a drain emits.
	task automatic apply_request(input logic act, input logic [63:0] d);
		rect_t nb, u;
		damage_out_t r;
		int i;
		if (act == drac_pkg::ACT_DRAIN) begin
			n_drains++;
			if (rect_count == 0) begin
				r = '0;
				r.last = 1'b1;
				drained_rects_q.push_back(r);
			end
			for (i = 0; i < rect_count; i++) begin
				r.x        = rect_list[i].x[14:0];
				r.y        = rect_list[i].y[14:0];
				r.w        = rect_list[i].w[15:0];
				r.h        = rect_list[i].h[15:0];
				r.occupied = 1'b1;
				r.last     = (i == rect_count - 1);
				drained_rects_q.push_back(r);
			end
			rect_count = 0;
			return;
		end
		n_adds++;
		nb.x = int'($signed(d[14:0]));
		nb.y = int'($signed(d[29:15]));
		nb.w = int'(d[44:30]);
		nb.h = int'(d[59:45]);
		if (nb.w == 0 || nb.h == 0) begin
			n_ignored++;
			return;
		end
		for (i = 0; i < rect_count; i++) begin
			u = bounding_box(rect_list[i], nb);
			if (covered_area(u) <= covered_area(rect_list[i]) + covered_area(nb)
			    + longint'(merge_slack)) begin
				rect_list[i] = u;
				return;
			end
		end
		if (rect_count < drac_pkg::MAX_RECTS) begin
			rect_list[rect_count] = nb;
			rect_count++;
			return;
		end
		// list full: collapse everything into one bounding box
		for (i = 0; i < drac_pkg::MAX_RECTS; i++)
			nb = bounding_box(nb, rect_list[i]);
		rect_list[0] = nb;
		rect_count = 1;
	endtask

	always @(posedge clk) begin
		damage_out_t got, want;
		req_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				merge_slack = int'(cfg_data);
			if (s_tvalid && s_tready)
				apply_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				n_results++;
				got.x        = m_tdata[14:0];
				got.y        = m_tdata[29:15];
				got.w        = m_tdata[45:30];
				got.h        = m_tdata[61:46];
				got.occupied = m_tuser;
				got.last     = m_tlast;
				if (drained_rects_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result x=%0d y=%0d w=%0d h=%0d valid=%b last=%b",
						$realtime, $signed(got.x), $signed(got.y), got.w, got.h,
						got.occupied, got.last);
				end else begin
					want = drained_rects_q.pop_front();
					if (got !== want) begin
						error_count++;
						$display("%0t: mismatch expected x=%0d y=%0d w=%0d h=%0d valid=%b last=%b",
							$realtime, $signed(want.x), $signed(want.y), want.w, want.h,
							want.occupied, want.last);
						$display("%0t:           actual x=%0d y=%0d w=%0d h=%0d valid=%b last=%b",
							$realtime, $signed(got.x), $signed(got.y), got.w, got.h,
							got.occupied, got.last);
					end
				end
			end
		end
	end

	// Drive requests and backpressure away from the sampling edge.
	always @(negedge clk) begin
		drac_pkg::item_t nxt;
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		if (!s_tvalid || req_taken) begin
			if (arst_n && request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = request_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= nxt.action;
				s_tdata  <= {4'b0000, nxt.h, nxt.w, nxt.y, nxt.x};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic push_add(input int x, input int y, input int w, input int h);
		drac_pkg::item_t it;
		it.action = drac_pkg::ACT_ADD;
		it.x = x[14:0];
		it.y = y[14:0];
		it.w = w[14:0];
		it.h = h[14:0];
		request_q.push_back(it);
	endtask

	// Payload of a drain is don't-care; fill it with noise.
	task automatic push_drain();
		drac_pkg::item_t it;
		it.action = drac_pkg::ACT_DRAIN;
		it.x = 15'($urandom);
		it.y = 15'($urandom);
		it.w = 15'($urandom);
		it.h = 15'($urandom);
		request_q.push_back(it);
	endtask

	task automatic queue_random_requests(input int count);
		int cx[4], cy[4];
		int k, c, roll;
		for (k = 0; k < 4; k++) begin
			cx[k] = int'($urandom_range(30000)) - 15000;
			cy[k] = int'($urandom_range(30000)) - 15000;
		end
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			c = $urandom_range(3);
			if (roll < 12) begin
				push_drain();
			end else if (roll < 18) begin
				if ($urandom_range(1))
					push_add(int'($urandom_range(32767)) - 16384, cy[c], 0,
						$urandom_range(32767));
				else
					push_add(cx[c], int'($urandom_range(32767)) - 16384,
						$urandom_range(32767), 0);
			end else if (roll < 32) begin
				push_add(int'($urandom_range(32767)) - 16384,
					int'($urandom_range(32767)) - 16384,
					$urandom_range(32767), $urandom_range(32767));
			end else begin
				// clustered small rectangles, so merges and appends both happen
				push_add(cx[c] + int'($urandom_range(150)), cy[c] + int'($urandom_range(150)),
					$urandom_range(1, 48), $urandom_range(1, 48));
			end
		end
	endtask

	task automatic wait_quiet();
		while (request_q.size() > 0 || s_tvalid || drained_rects_q.size() > 0)
			@(posedge clk);
		// an add gives no result, so allow its longest pass to finish
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slack(input logic [15:0] value);
		wait_quiet();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int i;
		send_idle_pct = 30;
		recv_idle_pct = 62;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset slack
		push_drain();
		push_add(5, 5, 0, 20);
		push_add(5, 5, 20, 0);
		push_drain();
		push_add(0, 0, 10, 10);
		push_add(10, 0, 10, 10);
		push_add(100, 100, 4, 4);
		push_drain();
		push_add(-16384, -16384, 32767, 32767);
		push_add(16383, 16383, 32767, 32767);
		push_add(-1, -1, 1, 1);
		push_drain();
		// nine far-apart boxes overflow the list and force a collapse
		for (i = 0; i < drac_pkg::MAX_RECTS; i++)
			push_add(-16384 + i * 4000, -16384 + i * 3000, 1, 1);
		push_add(16383, 16383, 32767, 32767);
		push_drain();

		write_slack(16'd0);
		queue_random_requests(40);
		write_slack(16'hFFFF);
		queue_random_requests(40);
		wait_quiet();
		send_idle_pct = 62;
		recv_idle_pct = 30;
		write_slack(16'($urandom_range(2000)));
		queue_random_requests(40);
		wait_quiet();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_slack(drac_pkg::SLACK_RESET);
		queue_random_requests(40);
		wait_quiet();

		$display("run covered %0d adds (%0d empty), %0d drains, %0d rectangles checked",
			n_adds, n_ignored, n_drains, n_results);
		$display("slack settings 0, 65535, random and default; idle mixes on both sides");
		if (error_count == 0) begin
			$display("damage_rect_accumulator_test: clean");
		end else begin
			$display("damage_rect_accumulator_test: errors");
		end
		$finish;
	end

endmodule
